// File: hw/rtl/vdh_pkg.sv
package vdh_pkg;

    // store and bucket table sizes (both powers of two)
    localparam int STORE_DEPTH  = 4096;
    localparam int BUCKET_COUNT = 4096;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int CNT_W  = IDX_W + 1;
    localparam int BKT_W  = $clog2(BUCKET_COUNT);

    // fixed field widths of the ports
    localparam int KEY_W   = 12;
    localparam int VIDX_W  = 12;
    localparam int WORD_W  = 32;
    localparam int N_WORDS = 8;

    typedef logic [N_WORDS-1:0][WORD_W-1:0] t_vtx;

    // one store entry: vertex words, owning bucket, chain head flag, successor
    typedef struct packed {
        t_vtx             vtx;
        logic [BKT_W-1:0] bkt;
        logic             is_head;
        logic             lnk_vld;
        logic [IDX_W-1:0] lnk;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HEAD,
        ST_WALK,
        ST_LINK
    } t_state;

    localparam logic KIND_ADD   = 1'b0;
    localparam logic KIND_CLEAR = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

endpackage

// File: hw/rtl/vdh_ram.sv
module vdh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// File: hw/rtl/vertex_dedup_hash_table.sv
// Channel   | Direction | Handshake            | Payload
// ----------+-----------+----------------------+---------------------------------------
// item      | in        | start & !busy        | i_kind, i_bucket_key, 8 vertex words
// result    | out       | o_valid (one cycle)  | o_vertex_index, o_was_new, o_status
//
// A clear beat is taken from idle and its result strobes the next cycle.
// An add beat reads its bucket head in ST_HEAD, then probes the chain in ST_WALK
// (one entry RAM read per entry; an empty bucket still spends one probe on its
// stale head), and a miss that links behind an existing tail also passes ST_LINK.
// busy drops in the strobe cycle, so the next beat can be taken with the result.
// Synchronous active-low reset; no clearing pass: the bucket table is validated
// through the entry it points at. Results cannot be stalled: o_valid is a strobe.
module vertex_dedup_hash_table
    import vdh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_kind,
    input  logic [KEY_W-1:0]  i_bucket_key,
    input  logic [WORD_W-1:0] i_pos_x,
    input  logic [WORD_W-1:0] i_pos_y,
    input  logic [WORD_W-1:0] i_pos_z,
    input  logic [WORD_W-1:0] i_tex_u,
    input  logic [WORD_W-1:0] i_tex_v,
    input  logic [WORD_W-1:0] i_norm_x,
    input  logic [WORD_W-1:0] i_norm_y,
    input  logic [WORD_W-1:0] i_norm_z,
    output logic              o_valid,
    output logic [VIDX_W-1:0] o_vertex_index,
    output logic              o_was_new,
    output logic              o_status
);

    // Memories:
    //   bucket RAM: head index per bucket. Never cleared; a head is trusted only
    //     if it is below the vertex count and the entry there names this bucket
    //     and carries the head flag. Entries below the count are all rewritten
    //     since the last clear, so this reproduces bucket_used exactly.
    //   entry RAM: vertex words, bucket, head flag and chain link per index.
    // The chain tail is the last entry probed on a miss, so no tail table is
    // kept; its copy in r_ent is written back with the new link.

    t_state             r_state, n_state;
    logic [BKT_W-1:0]   r_key, n_key;
    t_vtx               r_vtx, n_vtx;
    logic [IDX_W-1:0]   r_cur, n_cur;
    logic               r_first, n_first;
    t_entry             r_ent, n_ent;
    logic [IDX_W-1:0]   r_new, n_new;
    logic [CNT_W-1:0]   r_count, n_count;

    logic               r_out_valid, n_out_valid;
    logic [VIDX_W-1:0]  r_out_index, n_out_index;
    logic               r_out_new, n_out_new;
    logic               r_out_status, n_out_status;

    logic               bram_we;
    logic [BKT_W-1:0]   bram_waddr, bram_raddr;
    logic [IDX_W-1:0]   bram_wdata, bram_rdata;

    logic               eram_we;
    logic [IDX_W-1:0]   eram_waddr, eram_raddr;
    t_entry             eram_wdata, eram_rdata;

    logic               head_ok;
    logic               hit;

    vdh_ram #(
        .WIDTH (IDX_W),
        .DEPTH (BUCKET_COUNT)
    ) u_bucket_ram (
        .i_clk   (i_clk),
        .i_we    (bram_we),
        .i_waddr (bram_waddr),
        .i_wdata (bram_wdata),
        .i_raddr (bram_raddr),
        .o_rdata (bram_rdata)
    );

    vdh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_entry_ram (
        .i_clk   (i_clk),
        .i_we    (eram_we),
        .i_waddr (eram_waddr),
        .i_wdata (eram_wdata),
        .i_raddr (eram_raddr),
        .o_rdata (eram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_vtx        <= n_vtx;
        r_cur        <= n_cur;
        r_first      <= n_first;
        r_ent        <= n_ent;
        r_new        <= n_new;
        r_out_index  <= n_out_index;
        r_out_new    <= n_out_new;
        r_out_status <= n_out_status;
    end

    // probe qualifiers; written as ifs so an unwritten head reads as unused
    always_comb begin
        head_ok = 1'b0;
        hit     = 1'b0;
        if (({1'b0, r_cur} < r_count) && (eram_rdata.bkt == r_key) && eram_rdata.is_head) begin
            head_ok = 1'b1;
        end
        if (eram_rdata.vtx == r_vtx) begin
            hit = 1'b1;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_key        = r_key;
        n_vtx        = r_vtx;
        n_cur        = r_cur;
        n_first      = r_first;
        n_ent        = r_ent;
        n_new        = r_new;
        n_count      = r_count;
        n_out_valid  = 1'b0;
        n_out_index  = r_out_index;
        n_out_new    = r_out_new;
        n_out_status = r_out_status;

        bram_we    = 1'b0;
        bram_waddr = r_key;
        bram_wdata = r_count[IDX_W-1:0];
        // key reduced modulo the bucket count (a power of two)
        bram_raddr = i_bucket_key[BKT_W-1:0];

        eram_we            = 1'b0;
        eram_waddr         = r_count[IDX_W-1:0];
        eram_wdata.vtx     = r_vtx;
        eram_wdata.bkt     = r_key;
        eram_wdata.is_head = 1'b1;
        eram_wdata.lnk_vld = 1'b0;
        eram_wdata.lnk     = '0;
        eram_raddr         = r_cur;

        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    if (i_kind == KIND_CLEAR) begin
                        n_count      = '0;
                        n_out_valid  = 1'b1;
                        n_out_index  = '0;
                        n_out_new    = 1'b0;
                        n_out_status = STATUS_OK;
                    end else begin
                        n_key   = i_bucket_key[BKT_W-1:0];
                        n_vtx   = {i_norm_z, i_norm_y, i_norm_x, i_tex_v,
                                   i_tex_u, i_pos_z, i_pos_y, i_pos_x};
                        n_state = ST_HEAD;
                    end
                end
            end

            ST_HEAD: begin
                n_cur      = bram_rdata;
                eram_raddr = bram_rdata;
                n_first    = 1'b1;
                n_state    = ST_WALK;
            end

            ST_WALK: begin
                n_first = 1'b0;
                if ((!r_first || head_ok) && hit) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = VIDX_W'(r_cur);
                    n_out_new    = 1'b0;
                    n_out_status = STATUS_OK;
                    n_state      = ST_IDLE;
                end else if ((!r_first || head_ok) && eram_rdata.lnk_vld) begin
                    n_cur      = eram_rdata.lnk;
                    eram_raddr = eram_rdata.lnk;
                end else if (r_count == CNT_W'(STORE_DEPTH)) begin
                    n_out_valid  = 1'b1;
                    n_out_index  = '0;
                    n_out_new    = 1'b0;
                    n_out_status = STATUS_FULL;
                    n_state      = ST_IDLE;
                end else begin
                    // append at index count
                    eram_we = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    n_new   = r_count[IDX_W-1:0];
                    if (r_first && !head_ok) begin
                        // empty bucket: new entry becomes its head
                        bram_we      = 1'b1;
                        n_out_valid  = 1'b1;
                        n_out_index  = VIDX_W'(r_count[IDX_W-1:0]);
                        n_out_new    = 1'b1;
                        n_out_status = STATUS_OK;
                        n_state      = ST_IDLE;
                    end else begin
                        eram_wdata.is_head = 1'b0;
                        n_ent              = eram_rdata;
                        n_state            = ST_LINK;
                    end
                end
            end

            ST_LINK: begin
                // write the tail back with its new successor
                eram_we            = 1'b1;
                eram_waddr         = r_cur;
                eram_wdata         = r_ent;
                eram_wdata.lnk_vld = 1'b1;
                eram_wdata.lnk     = r_new;
                n_out_valid        = 1'b1;
                n_out_index        = VIDX_W'(r_new);
                n_out_new          = 1'b1;
                n_out_status       = STATUS_OK;
                n_state            = ST_IDLE;
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_valid        = r_out_valid;
    assign o_vertex_index = r_out_index;
    assign o_was_new      = r_out_new;
    assign o_status       = r_out_status;

endmodule

// File: hw/rtl/vdh_chk.sv
module vdh_chk
    import vdh_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              i_kind,
    input logic              o_valid,
    input logic [VIDX_W-1:0] o_vertex_index,
    input logic              o_was_new,
    input logic              o_status
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !busy && !o_valid)
        else $error("busy or strobe after reset");

    a_clear_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == KIND_CLEAR) |=>
            o_valid && (o_vertex_index == '0) && !o_was_new && (o_status == STATUS_OK))
        else $error("clear beat gave wrong result");

    a_add_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_kind == KIND_ADD) |=> busy && !o_valid)
        else $error("add beat did not go busy");

    a_done_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) && $past(i_rst_n) |-> o_valid)
        else $error("busy dropped without a result");

    a_full_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == STATUS_FULL) |-> !o_was_new && (o_vertex_index == '0))
        else $error("full result carries index or new flag");

endmodule

bind vertex_dedup_hash_table vdh_chk u_vdh_chk (.*);
